// File: rtl/interval_room_counter_defines.svh
// Assertion macros shared by the room counter modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef INTERVAL_ROOM_COUNTER_DEFINES_SVH
`define INTERVAL_ROOM_COUNTER_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define IRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define IRC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/irc_pkg.sv
package irc_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int TIME_W     = 31;
	localparam int RC_W       = 11;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	// Wide enough for a child index 2*i+2 and for the heap size.
	localparam int WIDE_W     = IDX_W + 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT_RD,
		ST_ROOT_CMP,
		ST_SD_RD,
		ST_SD_C1,
		ST_SD_C2,
		ST_SU_RD,
		ST_SU_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [RC_W-1:0] room_count;
		logic            overflow;
		logic            set_done;
	} res_t;

endpackage

// File: rtl/irc_in_if.sv
interface irc_in_if import irc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] end_time;
	logic              last_interval;

	modport source (output valid, output start_time, output end_time,
		output last_interval, input ready);
	modport sink (input valid, input start_time, input end_time,
		input last_interval, output ready);
endinterface

// File: rtl/irc_out_if.sv
interface irc_out_if import irc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [RC_W-1:0] room_count;
	logic            overflow;
	logic            set_done;

	modport source (output valid, output room_count, output overflow,
		output set_done, input ready);
	modport sink (input valid, input room_count, input overflow,
		input set_done, output ready);
endinterface

// File: rtl/irc_ram.sv
module irc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 31,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr0,
	input  logic [AW-1:0]    raddr1,
	output logic [WIDTH-1:0] rdata0,
	output logic [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// File: rtl/irc_seq.sv
`include "interval_room_counter_defines.svh"

module irc_seq import irc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [TIME_W-1:0] req_start,
	input  logic [TIME_W-1:0] req_end,
	input  logic              req_last,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	state_t state_q, state_d;

	logic [TIME_W-1:0] start_q, v_q, cm_q;
	logic [IDX_W-1:0]  i_q, m_q;
	logic [CNT_W-1:0]  size_q;
	logic              last_q, ovf_q, rok_q;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr0, ram_raddr1;
	logic [TIME_W-1:0] ram_wdata, rd0, rd1;

	logic [TIME_W-1:0] cmp_a, cmp_b;
	logic              cmp_lt;

	logic [WIDE_W-1:0] lc_w, rc_w, size_w;
	logic              l_ok, r_ok, freed, full;
	logic [IDX_W-1:0]  par;

	irc_ram #(
		.DEPTH (HEAP_DEPTH),
		.WIDTH (TIME_W),
		.AW    (IDX_W)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr0 (ram_raddr0),
		.raddr1 (ram_raddr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// The one comparator; each state picks its operands.
	assign cmp_lt = cmp_a < cmp_b;

	assign lc_w   = {1'b0, i_q, 1'b1};
	assign rc_w   = lc_w + WIDE_W'(1);
	assign size_w = WIDE_W'(size_q);
	assign l_ok   = lc_w < size_w;
	assign r_ok   = rc_w < size_w;
	assign par    = IDX_W'((i_q - IDX_W'(1)) >> 1);
	assign full   = size_q == CNT_W'(HEAP_DEPTH);
	// In the root compare state the comparator tests start < root.
	assign freed  = (size_q != '0) && !cmp_lt;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_ROOT_RD;
			end
			ST_ROOT_RD: state_d = ST_ROOT_CMP;
			ST_ROOT_CMP: begin
				if (freed) state_d = ST_SD_RD;
				else if (!full) state_d = ST_SU_RD;
				else state_d = ST_DONE;
			end
			ST_SD_RD: begin
				state_d = l_ok ? ST_SD_C1 : ST_DONE;
			end
			ST_SD_C1: state_d = ST_SD_C2;
			ST_SD_C2: begin
				state_d = cmp_lt ? ST_SD_RD : ST_DONE;
			end
			ST_SU_RD: begin
				state_d = (i_q == '0) ? ST_DONE : ST_SU_CMP;
			end
			ST_SU_CMP: begin
				state_d = cmp_lt ? ST_SU_RD : ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		res_valid  = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = i_q;
		ram_wdata  = v_q;
		ram_re     = 1'b0;
		ram_raddr0 = '0;
		ram_raddr1 = '0;
		cmp_a      = v_q;
		cmp_b      = rd0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_ROOT_RD: ram_re = 1'b1;
			ST_ROOT_CMP: begin
				cmp_a = start_q;
				cmp_b = rd0;
			end
			ST_SD_RD: begin
				if (l_ok) begin
					ram_re     = 1'b1;
					ram_raddr0 = lc_w[IDX_W-1:0];
					ram_raddr1 = rc_w[IDX_W-1:0];
				end else begin
					ram_we = 1'b1;
				end
			end
			ST_SD_C1: begin
				cmp_a = rd1;
				cmp_b = rd0;
			end
			ST_SD_C2: begin
				cmp_a     = cm_q;
				cmp_b     = v_q;
				ram_we    = 1'b1;
				ram_wdata = cmp_lt ? cm_q : v_q;
			end
			ST_SU_RD: begin
				if (i_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re     = 1'b1;
					ram_raddr0 = par;
				end
			end
			ST_SU_CMP: begin
				cmp_a     = v_q;
				cmp_b     = rd0;
				ram_we    = 1'b1;
				ram_wdata = cmp_lt ? rd0 : v_q;
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROOT_CMP && !freed && !full) begin
				size_q <= size_q + CNT_W'(1);
			end
			if (state_q == ST_DONE && res_ready && last_q) begin
				size_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					start_q <= req_start;
					v_q     <= req_end;
					last_q  <= req_last;
					ovf_q   <= 1'b0;
				end
			end
			ST_ROOT_CMP: begin
				// A freed room takes the new end at the root, then sifts down.
				if (freed) i_q <= '0;
				else if (!full) i_q <= IDX_W'(size_q);
				else ovf_q <= 1'b1;
			end
			ST_SD_RD: rok_q <= r_ok;
			ST_SD_C1: begin
				if (rok_q && cmp_lt) begin
					cm_q <= rd1;
					m_q  <= rc_w[IDX_W-1:0];
				end else begin
					cm_q <= rd0;
					m_q  <= lc_w[IDX_W-1:0];
				end
			end
			ST_SD_C2: begin
				if (cmp_lt) i_q <= m_q;
			end
			ST_SU_CMP: begin
				if (cmp_lt) i_q <= par;
			end
			default: ;
		endcase
	end

	assign res.room_count = RC_W'(size_q);
	assign res.overflow   = ovf_q;
	assign res.set_done   = last_q;

	`IRC_ASSERT_ALWAYS(a_size_bound, size_q <= CNT_W'(HEAP_DEPTH), "heap size above depth")
	`IRC_ASSERT_SAME(a_write_in_heap, ram_we, WIDE_W'(ram_waddr) < size_w,
		"heap write outside the filled part")
	`IRC_ASSERT_SAME(a_ovf_full, res_valid && res.overflow, full,
		"overflow reported with room left in the heap")
	`IRC_ASSERT_NEXT(a_last_clears, res_valid && res_ready && last_q, size_q == '0,
		"heap not cleared after the last interval")

endmodule

// File: rtl/interval_room_counter.sv
// Interval room counter: takes intervals sorted by start time and returns, for each,
// the number of rooms in use, kept as a min-heap of end times in a 1024-entry memory
// with one write and two registered read ports. One request is processed at a time:
// the root is read and then compared with the start, then the end time either replaces
// a freed root and sifts down, each level reading both children, picking the smaller
// and comparing it with the end, or is appended and sifts up, each level reading the
// parent and comparing it with the end; a dropped interval goes straight to the result.
// The single shared comparator serves every compare step. The result waits in an
// output register, so the next request is taken while it is still pending. A full
// heap with no freed room drops the interval and flags overflow; the last interval
// of a set reports the final count and empties the heap.
// The heap memory needs no clearing pass after reset, since only entries below the
// fill count ever affect a result.
module interval_room_counter import irc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	irc_in_if.sink   intervals,
	irc_out_if.source results
);

	logic res_valid, res_ready, out_valid_q;
	res_t res, res_q;

	irc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (intervals.valid),
		.req_ready (intervals.ready),
		.req_start (intervals.start_time),
		.req_end   (intervals.end_time),
		.req_last  (intervals.last_interval),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.room_count = res_q.room_count;
	assign results.overflow   = res_q.overflow;
	assign results.set_done   = res_q.set_done;

endmodule
